// ===== rtl/pfd_pkg.sv =====
// Shared constants, types and controller codes of the PPM frame decoder.
package pfd_pkg;

    localparam int DUR_W      = 16;
    localparam int VALUE_W    = 16;
    localparam int CHAN_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // |raw - min| * 2000 needs 27 bits.
    localparam int PROD_W     = 27;
    // Signed quotient with the offset applied.
    localparam int SCALED_W   = PROD_W + 2;

    localparam int CHANNELS_DEFAULT = 8;

    localparam logic [DUR_W-1:0]      SYNC_GAP_TICKS = 16'd4000;
    localparam logic [10:0]           SCALE_SPAN     = 11'd2000;
    localparam logic [SCALED_W-1:0]   SCALE_OFFSET   = 29'd1000;
    localparam logic [CFG_DATA_W-1:0] MAX_RESET      = 16'd1600;
    localparam logic [CFG_DATA_W-1:0] MIN_RESET      = 16'd1000;

    localparam logic [CFG_IDX_W-1:0]  CFG_PULSE_MAX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_PULSE_MIN  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } pfd_state_t;

    typedef struct packed {
        logic accept;
        logic start_frame;
        logic mul;
        logic next_chan;
        logic load_out;
    } pfd_cmd_t;

    typedef struct packed {
        logic frame_complete;
        logic div_done;
        logic out_free;
        logic last_chan;
    } pfd_status_t;

endpackage

// ===== rtl/pfd_if.sv =====
// Request channels of the PPM frame decoder: edge events in, scaled channels out.
interface pfd_in_if;
    import pfd_pkg::*;

    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] duration;

    modport source (output valid, output duration, input ready);
    modport sink   (input valid, input duration, output ready);
endinterface

interface pfd_out_if;
    import pfd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CHAN_W-1:0]         channel;
    logic signed [VALUE_W-1:0] value;
    logic                      range_error;
    logic                      last;

    modport source (output valid, output channel, output value, output range_error,
                    output last, input ready);
    modport sink   (input valid, input channel, input value, input range_error,
                    input last, output ready);
endinterface

// ===== rtl/ppm_frame_decoder.sv =====
// Top level of the PPM frame decoder: controller, datapath and request channels.
//
// Edge requests are taken only while the controller is idle. The edge that completes a frame
// starts scaling; each channel then passes a multiply state, the bit-serial divider with one
// step per quotient bit and a result state, so a frame gives CHANNELS results, and an output
// stall holds the sequence. No new edge is taken until the last result of the frame is loaded.
// Reset clears the channel index, the sync flag and the stored widths and loads the
// pulse limits with 1600 and 1000 ticks.
module ppm_frame_decoder #(
    parameter int CHANNELS = pfd_pkg::CHANNELS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pfd_in_if.sink                          edges,
    pfd_out_if.source                       results,
    input  logic                            cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pfd_pkg::*;

    // The controller owns the handshake on the edge channel and steps the datapath
    // through multiply, divide and result load for every channel of a finished frame.
    pfd_cmd_t    cmd;
    pfd_status_t status;

    pfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (edges.valid),
        .in_ready (edges.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the pulse limits, the frame position, the raw widths and the
    // result register, which lets a new edge request in while a result still waits.
    pfd_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .duration        (edges.duration),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (results.valid),
        .out_ready       (results.ready),
        .out_channel     (results.channel),
        .out_value       (results.value),
        .out_range_error (results.range_error),
        .out_last        (results.last)
    );

endmodule

// ===== rtl/pfd_divider.sv =====
// Restoring unsigned divider that retires one quotient bit per cycle.
module pfd_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pfd_pkg::PROD_W-1:0]   dividend,
    input  logic [pfd_pkg::DUR_W-1:0]    divisor,
    output logic [pfd_pkg::PROD_W-1:0]   quotient,
    output logic                         done
);
    import pfd_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    logic [DUR_W:0]    rem_shift;
    logic [DUR_W:0]    rem_trial;
    logic              fits;

    assign rem_shift = {rem_reg, quo_reg[PROD_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor};
    assign rem_trial = rem_shift - {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[PROD_W-2:0], fits};
            rem_next = fits ? rem_trial[DUR_W-1:0] : rem_shift[DUR_W-1:0];
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign done     = busy_reg && (cnt_reg == LAST_STEP);

    a_no_restart_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n) start |-> !busy_reg
    ) else $error("divider restarted while busy");

    a_done_ends_run: assert property (
        @(posedge clk) disable iff (!rst_n) done |=> !busy_reg
    ) else $error("divider still busy after its final step");

endmodule

// ===== rtl/pfd_ctrl.sv =====
// Controller state machine that sequences edge intake and per-channel scaling.
module pfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pfd_pkg::pfd_status_t status,
    output pfd_pkg::pfd_cmd_t    cmd
);
    import pfd_pkg::*;

    pfd_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.frame_complete)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_chan ? S_IDLE : S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.accept      = in_valid;
                cmd.start_frame = in_valid && status.frame_complete;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            S_DIV:
            begin
                cmd = '0;
            end
            S_OUT:
            begin
                cmd.load_out  = status.out_free;
                cmd.next_chan = status.out_free && !status.last_chan;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_frame_starts_with_mul: assert property (
        @(posedge clk) disable iff (!rst_n) cmd.start_frame |=> state_reg == S_MUL
    ) else $error("completed frame did not start scaling");

endmodule

// ===== rtl/pfd_datapath.sv =====
// Datapath: configuration, frame state, raw width store, scaling and result register.
module pfd_datapath #(
    parameter int CHANNELS = pfd_pkg::CHANNELS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [pfd_pkg::DUR_W-1:0]        duration,
    input  pfd_pkg::pfd_cmd_t                cmd,
    output pfd_pkg::pfd_status_t             status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pfd_pkg::CHAN_W-1:0]       out_channel,
    output logic signed [pfd_pkg::VALUE_W-1:0] out_value,
    output logic                             out_range_error,
    output logic                             out_last
);
    import pfd_pkg::*;

    localparam int IDX_W = $clog2(CHANNELS + 1);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic signed [SCALED_W-1:0] SAT_HI = SCALED_W'(32767);
    localparam logic signed [SCALED_W-1:0] SAT_LO = -SCALED_W'(32768);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] pulse_max_reg, pulse_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_max_reg <= MAX_RESET;
            pulse_min_reg <= MIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PULSE_MAX: pulse_max_reg <= cfg_data;
                CFG_PULSE_MIN: pulse_min_reg <= cfg_data;
                default:       pulse_max_reg <= pulse_max_reg;
            endcase
        end
    end

    // Frame tracking and raw width capture.
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             sync_reg, sync_next;
    logic [DUR_W-1:0] raw_reg [CHANNELS];

    logic [IDX_W-1:0] eff_idx;
    logic [IDX_W-1:0] idx_inc;
    logic             store_ok;

    assign eff_idx  = sync_reg ? '0 : idx_reg;
    assign idx_inc  = eff_idx + IDX_W'(1);
    assign store_ok = (duration < SYNC_GAP_TICKS) && (eff_idx < IDX_W'(CHANNELS));

    always_comb
    begin
        idx_next  = idx_reg;
        sync_next = sync_reg;
        if (cmd.accept)
        begin
            if (store_ok)
            begin
                idx_next  = idx_inc;
                sync_next = 1'b0;
            end
            else
            begin
                idx_next  = '0;
                sync_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            sync_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                raw_reg[i] <= '0;
            end
        end
        else
        begin
            idx_reg  <= idx_next;
            sync_reg <= sync_next;
            if (cmd.accept && store_ok)
            begin
                raw_reg[eff_idx[CH_W-1:0]] <= duration;
            end
        end
    end

    // Channel sequencing over the stored frame.
    logic [CH_W-1:0] ch_reg, ch_next;

    always_comb
    begin
        ch_next = ch_reg;
        if (cmd.start_frame)
        begin
            ch_next = '0;
        end
        else if (cmd.next_chan)
        begin
            ch_next = ch_reg + CH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= '0;
        end
        else
        begin
            ch_reg <= ch_next;
        end
    end

    // Offset removal and multiply; the product is registered in the divider.
    logic signed [DUR_W:0] diff;
    logic [DUR_W-1:0]      mag;
    logic [PROD_W-1:0]     product;
    logic                  neg_reg;
    logic                  range_err;
    logic [DUR_W-1:0]      span;
    logic [PROD_W-1:0]     quotient;
    logic                  div_done;

    assign diff      = $signed({1'b0, raw_reg[ch_reg]}) - $signed({1'b0, pulse_min_reg});
    assign mag       = diff[DUR_W] ? DUR_W'(-diff) : diff[DUR_W-1:0];
    assign product   = PROD_W'(mag) * PROD_W'(SCALE_SPAN);
    assign range_err = pulse_max_reg <= pulse_min_reg;
    assign span      = pulse_max_reg - pulse_min_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            neg_reg <= diff[DUR_W];
        end
    end

    pfd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mul),
        .dividend (product),
        .divisor  (span),
        .quotient (quotient),
        .done     (div_done)
    );

    // Sign restore, offset and saturation, or zero when the pulse limits are out of order.
    logic signed [SCALED_W-1:0] q_signed;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [VALUE_W-1:0]  sat_value;

    assign q_signed = neg_reg ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
    assign scaled   = q_signed - $signed(SCALE_OFFSET);

    always_comb
    begin
        priority if (range_err)
        begin
            sat_value = '0;
        end
        else if (scaled > SAT_HI)
        begin
            sat_value = SAT_HI[VALUE_W-1:0];
        end
        else if (scaled < SAT_LO)
        begin
            sat_value = SAT_LO[VALUE_W-1:0];
        end
        else
        begin
            sat_value = scaled[VALUE_W-1:0];
        end
    end

    // Result register.
    logic                      out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]         chan_out_reg;
    logic signed [VALUE_W-1:0] value_out_reg;
    logic                      err_out_reg;
    logic                      last_out_reg;
    logic                      last_chan;

    assign last_chan = ch_reg == CH_W'(CHANNELS - 1);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            chan_out_reg  <= CHAN_W'(ch_reg);
            value_out_reg <= sat_value;
            err_out_reg   <= range_err;
            last_out_reg  <= last_chan;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_channel     = chan_out_reg;
    assign out_value       = value_out_reg;
    assign out_range_error = err_out_reg;
    assign out_last        = last_out_reg;

    assign status.frame_complete = store_ok && (idx_inc == IDX_W'(CHANNELS));
    assign status.div_done       = div_done;
    assign status.out_free       = !out_valid_reg || out_ready;
    assign status.last_chan      = last_chan;

    a_sync_clears_index: assert property (
        @(posedge clk) disable iff (!rst_n) sync_reg |-> idx_reg == '0
    ) else $error("sync flag set with a non-zero channel index");

    a_load_into_free_slot: assert property (
        @(posedge clk) disable iff (!rst_n) cmd.load_out |-> (!out_valid_reg || out_ready)
    ) else $error("result loaded over one not yet taken");

    a_frame_rewinds_channel: assert property (
        @(posedge clk) disable iff (!rst_n) cmd.start_frame |=> ch_reg == '0
    ) else $error("frame scaling did not start at channel zero");

endmodule
